>>> src/fifo_ready_queue_with_removal_defines.svh
// Assertion macros for the ready queue design.
// Included by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FIFO_READY_QUEUE_WITH_REMOVAL_DEFINES_SVH
`define FIFO_READY_QUEUE_WITH_REMOVAL_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define FRQ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ready queue check failed");

// Check a consequence in the cycle after its cause
`define FRQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ready queue check failed");

`endif

>>> src/frq_pkg.sv
// Shared types, codes and the microcode program of the ready queue.
// No dependencies; used by frq_seq, frq_dp and the top level.
`default_nettype none

package frq_pkg;

    // Field widths of the transactions
    localparam int REQ_TYPE_W = 2;
    localparam int THREAD_ID_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;

    // Parameter defaults
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH = 8;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [THREAD_ID_W-1:0] thread_id;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [THREAD_ID_W-1:0] dispatched_id;
        logic [COUNT_W-1:0]     entries_removed;
        logic [COUNT_W-1:0]     queue_count;
    } rsp_item_t;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PUSH,
        OP_SET_FULL,
        OP_READ_HEAD,
        OP_POP,
        OP_SET_EMPTY,
        OP_WALK_INIT,
        OP_WALK,
        OP_WALK_END,
        OP_DONE
    } op_t;

    // Jump conditions; a false condition falls through to the next step
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DISPATCH,
        C_FULL,
        C_EMPTY,
        C_WALK_BUSY,
        C_OUT_BLOCKED
    } cond_t;

    localparam int UPC_W = 4;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    // Status from the datapath that the sequencer branches on
    typedef struct packed {
        logic                  no_input;
        logic                  full;
        logic                  empty;
        logic                  walk_busy;
        logic                  out_blocked;
        logic [REQ_TYPE_W-1:0] req_code;
    } flags_t;

    // Step addresses
    localparam logic [UPC_W-1:0] S_FETCH = 4'd0;
    localparam logic [UPC_W-1:0] S_DECODE = 4'd1;
    localparam logic [UPC_W-1:0] S_ENQ_TEST = 4'd2;
    localparam logic [UPC_W-1:0] S_ENQ_WRITE = 4'd3;
    localparam logic [UPC_W-1:0] S_ENQ_FULL = 4'd4;
    localparam logic [UPC_W-1:0] S_DEQ_READ = 4'd5;
    localparam logic [UPC_W-1:0] S_DEQ_POP = 4'd6;
    localparam logic [UPC_W-1:0] S_DEQ_EMPTY = 4'd7;
    localparam logic [UPC_W-1:0] S_REM_INIT = 4'd8;
    localparam logic [UPC_W-1:0] S_REM_WALK = 4'd9;
    localparam logic [UPC_W-1:0] S_REM_END = 4'd10;
    // Last address: falling through wraps the step counter back to fetch
    localparam logic [UPC_W-1:0] S_RESULT = 4'd15;

    // Microcode program
    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: S_FETCH};
        unique case (addr)
            S_FETCH:     w = '{op: OP_LATCH,     cond: C_NO_INPUT,    target: S_FETCH};
            S_DECODE:    w = '{op: OP_NONE,      cond: C_DISPATCH,    target: S_FETCH};
            S_ENQ_TEST:  w = '{op: OP_NONE,      cond: C_FULL,        target: S_ENQ_FULL};
            S_ENQ_WRITE: w = '{op: OP_PUSH,      cond: C_ALWAYS,      target: S_RESULT};
            S_ENQ_FULL:  w = '{op: OP_SET_FULL,  cond: C_ALWAYS,      target: S_RESULT};
            S_DEQ_READ:  w = '{op: OP_READ_HEAD, cond: C_EMPTY,       target: S_DEQ_EMPTY};
            S_DEQ_POP:   w = '{op: OP_POP,       cond: C_ALWAYS,      target: S_RESULT};
            S_DEQ_EMPTY: w = '{op: OP_SET_EMPTY, cond: C_ALWAYS,      target: S_RESULT};
            S_REM_INIT:  w = '{op: OP_WALK_INIT, cond: C_NEVER,       target: S_FETCH};
            S_REM_WALK:  w = '{op: OP_WALK,      cond: C_WALK_BUSY,   target: S_REM_WALK};
            S_REM_END:   w = '{op: OP_WALK_END,  cond: C_ALWAYS,      target: S_RESULT};
            S_RESULT:    w = '{op: OP_DONE,      cond: C_OUT_BLOCKED, target: S_RESULT};
            default:     w = '{op: OP_NONE,      cond: C_ALWAYS,      target: S_FETCH};
        endcase
        return w;
    endfunction

    // Multiway jump on the request code
    function automatic logic [UPC_W-1:0] dispatch_step(input logic [REQ_TYPE_W-1:0] code);
        logic [UPC_W-1:0] s;
        unique case (code)
            REQ_ENQUEUE: s = S_ENQ_TEST;
            REQ_DEQUEUE: s = S_DEQ_READ;
            REQ_REMOVE:  s = S_REM_INIT;
            default:     s = S_RESULT;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/frq_seq.sv
// Microcode sequencer: step counter, control word fetch and jump logic.
// Depends on frq_pkg for the program, control word and flag types.
`default_nettype none

module frq_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  frq_pkg::flags_t flags,
    output frq_pkg::ctrl_t  ctrl
);
    import frq_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;

    // Fetch the current control word
    assign ctrl = ucode_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    // Pick the next step: jump target when the condition holds, else fall through; dispatch jumps on the request code
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:       upc_next = upc_inc;
            C_ALWAYS:      upc_next = ctrl.target;
            C_NO_INPUT:    upc_next = flags.no_input ? ctrl.target : upc_inc;
            C_DISPATCH:    upc_next = dispatch_step(flags.req_code);
            C_FULL:        upc_next = flags.full ? ctrl.target : upc_inc;
            C_EMPTY:       upc_next = flags.empty ? ctrl.target : upc_inc;
            C_WALK_BUSY:   upc_next = flags.walk_busy ? ctrl.target : upc_inc;
            C_OUT_BLOCKED: upc_next = flags.out_blocked ? ctrl.target : upc_inc;
            default:       upc_next = S_FETCH;
        endcase
    end

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

>>> src/frq_dp.sv
// Datapath of the ready queue: slot memory in two banks, pointers, counts, result register.
// Depends on frq_pkg and on the assertion macros in the defines header.
`default_nettype none

`include "fifo_ready_queue_with_removal_defines.svh"

module frq_dp #(
    parameter int QUEUE_DEPTH = frq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = frq_pkg::DEF_ID_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  frq_pkg::ctrl_t     ctrl,
    output frq_pkg::flags_t    flags,
    input  logic               req_valid,
    output logic               req_stall,
    input  frq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output frq_pkg::rsp_item_t rsp
);
    import frq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // Slot memory: the live bank holds the queue, the other receives a compacted copy
    logic [ID_WIDTH-1:0] mem [MEM_DEPTH];

    logic [REQ_TYPE_W-1:0] req_code_reg;
    logic [ID_WIDTH-1:0]   id_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_WIDTH-1:0]   disp_reg;
    logic [ID_WIDTH-1:0]   rdata_reg;
    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      tail_reg;
    logic [IDX_W-1:0]      walk_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      left_reg;
    logic [CNT_W-1:0]      kept_reg;
    logic [CNT_W-1:0]      removed_reg;
    logic                  bank_reg;
    logic                  pend_reg;
    logic                  rsp_valid_reg;
    rsp_item_t             rsp_reg;

    logic                  out_blocked;
    logic                  accept;
    logic                  walk_read;
    logic                  keep_hit;
    logic                  drop_hit;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [ID_WIDTH-1:0]   mem_wdata;
    logic                  load_rsp;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    // Decode the control word into strobes
    assign out_blocked = rsp_valid_reg && rsp_stall;
    assign accept      = (ctrl.op == OP_LATCH) && req_valid;
    assign walk_read   = (ctrl.op == OP_WALK) && (left_reg != '0);
    assign keep_hit    = (ctrl.op == OP_WALK) && pend_reg && (rdata_reg != id_reg);
    assign drop_hit    = (ctrl.op == OP_WALK) && pend_reg && (rdata_reg == id_reg);
    assign load_rsp    = (ctrl.op == OP_DONE) && !out_blocked;

    assign mem_we    = (ctrl.op == OP_PUSH) || keep_hit;
    assign mem_waddr = (ctrl.op == OP_PUSH) ? {bank_reg, tail_reg}
                                            : {~bank_reg, kept_reg[IDX_W-1:0]};
    assign mem_wdata = (ctrl.op == OP_PUSH) ? id_reg : rdata_reg;
    assign mem_re    = (ctrl.op == OP_READ_HEAD) || walk_read;
    assign mem_raddr = (ctrl.op == OP_READ_HEAD) ? {bank_reg, head_reg}
                                                 : {bank_reg, walk_ptr_reg};

    // Report status to the sequencer
    assign flags.no_input    = !req_valid;
    assign flags.full        = (count_reg == FULL_COUNT);
    assign flags.empty       = (count_reg == '0);
    assign flags.walk_busy   = (left_reg != '0);
    assign flags.out_blocked = out_blocked;
    assign flags.req_code    = req_code_reg;

    assign req_stall = (ctrl.op != OP_LATCH);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Write and read the slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Capture the request and build the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_code_reg <= req.req_type;
            id_reg       <= ID_WIDTH'(req.thread_id);
            status_reg   <= ST_OK;
            disp_reg     <= '0;
            removed_reg  <= '0;
        end
        if (ctrl.op == OP_SET_FULL)
        begin
            status_reg <= ST_FULL;
        end
        if (ctrl.op == OP_SET_EMPTY)
        begin
            status_reg <= ST_EMPTY;
        end
        if (ctrl.op == OP_POP)
        begin
            disp_reg <= rdata_reg;
        end
        if (drop_hit)
        begin
            removed_reg <= removed_reg + 1'b1;
        end
        if (ctrl.op == OP_WALK_INIT)
        begin
            walk_ptr_reg <= head_reg;
        end
        if (walk_read)
        begin
            walk_ptr_reg <= wrap_inc(walk_ptr_reg);
        end
        if (load_rsp)
        begin
            rsp_reg.status          <= status_reg;
            rsp_reg.dispatched_id   <= THREAD_ID_W'(disp_reg);
            rsp_reg.entries_removed <= COUNT_W'(removed_reg);
            rsp_reg.queue_count     <= COUNT_W'(count_reg);
        end
    end

    // Advance pointers, counts and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            kept_reg      <= '0;
            bank_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_PUSH:
                begin
                    tail_reg  <= wrap_inc(tail_reg);
                    count_reg <= count_reg + 1'b1;
                end
                OP_POP:
                begin
                    head_reg  <= wrap_inc(head_reg);
                    count_reg <= count_reg - 1'b1;
                end
                OP_WALK_INIT:
                begin
                    left_reg <= count_reg;
                    kept_reg <= '0;
                    pend_reg <= 1'b0;
                end
                OP_WALK:
                begin
                    pend_reg <= walk_read;
                    if (walk_read)
                    begin
                        left_reg <= left_reg - 1'b1;
                    end
                    if (keep_hit)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                OP_WALK_END:
                begin
                    bank_reg  <= ~bank_reg;
                    head_reg  <= '0;
                    tail_reg  <= (kept_reg == FULL_COUNT) ? '0 : kept_reg[IDX_W-1:0];
                    count_reg <= kept_reg;
                end
                default:
                begin
                end
            endcase

            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Checks on queue bookkeeping
    `FRQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_COUNT)
    `FRQ_ASSERT_NOW(a_walk_balance, ctrl.op == OP_WALK_END, kept_reg + removed_reg == count_reg)
    `FRQ_ASSERT_NEXT(a_push_count, ctrl.op == OP_PUSH, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `FRQ_ASSERT_NEXT(a_compact_swap, ctrl.op == OP_WALK_END, (head_reg == '0) && (bank_reg != $past(bank_reg)))

endmodule

`default_nettype wire

>>> src/fifo_ready_queue_with_removal.sv
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_stall  | frq_pkg::req_item_t  (req_type, thread_id)
// rsp     | out | rsp_valid/rsp_stall  | frq_pkg::rsp_item_t  (status, dispatched_id, ...)
//
// One request at a time, stepped by the microcode sequencer; a remove runs the
// compaction walk through the one read port of the slot memory.
// Reset empties the queue; slot contents are not cleared.
// A stalled result sits in the output register; the next request is still taken and
// run, and its result holds in the last step until the output register frees up.
// Top level: wires the sequencer to the datapath.
// Depends on frq_pkg, frq_seq and frq_dp.
`default_nettype none

module fifo_ready_queue_with_removal #(
    parameter int QUEUE_DEPTH = frq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = frq_pkg::DEF_ID_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  frq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output frq_pkg::rsp_item_t rsp
);
    import frq_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    // Step through the program
    frq_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Execute the control words
    frq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the ready queue with remove-by-id.
// Drives request transactions, predicts each response and compares it field by field.
// Depends on frq_pkg and fifo_ready_queue_with_removal.
module tb_top;
    import frq_pkg::*;

    localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
    localparam int ID_WIDTH = DEF_ID_WIDTH;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [THREAD_ID_W-1:0] ID_MASK = THREAD_ID_W'((1 << ID_WIDTH) - 1);
    // Request code 3 has no name in the package: it is a no-operation
    localparam logic [REQ_TYPE_W-1:0] REQ_NOP = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_item_t  req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp;

    // Shadow copy of the queue state
    logic [THREAD_ID_W-1:0] slot_copy [QUEUE_DEPTH];
    logic [PTR_W-1:0]       head_ptr;
    logic [PTR_W-1:0]       tail_ptr;
    logic [COUNT_W-1:0]     fill_count;

    rsp_item_t awaited_rsp [$];
    int        error_count;
    int        idle_cycles;
    bit        send_gaps;
    bit        stall_on;
    bit        hold_rsp_req;

    logic [THREAD_ID_W-1:0] id_pool [6] = '{8'h03, 8'h3C, 8'hC0, 8'hFF, 8'h00, 8'h81};

    fifo_ready_queue_with_removal #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_WIDTH(ID_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow queue and return the response it must give
    function automatic rsp_item_t predict_request(input req_item_t item);
        rsp_item_t              res;
        logic [THREAD_ID_W-1:0] kept [QUEUE_DEPTH];
        logic [THREAD_ID_W-1:0] id;
        int                     n_kept;
        int                     pos;
        int                     k;
        res = '0;
        n_kept = 0;
        id = item.thread_id & ID_MASK;
        case (item.req_type)
            REQ_ENQUEUE:
            begin
                if (fill_count < QUEUE_DEPTH)
                begin
                    slot_copy[tail_ptr] = id;
                    tail_ptr = tail_ptr + 1'b1;
                    fill_count = fill_count + 1'b1;
                end
                else
                    res.status = ST_FULL;
            end
            REQ_DEQUEUE:
            begin
                if (fill_count > 0)
                begin
                    res.dispatched_id = slot_copy[head_ptr];
                    head_ptr = head_ptr + 1'b1;
                    fill_count = fill_count - 1'b1;
                end
                else
                    res.status = ST_EMPTY;
            end
            REQ_REMOVE:
            begin
                // Walk from head, keep survivors in order, repack from slot zero
                pos = int'(head_ptr);
                for (k = 0; k < fill_count; k++)
                begin
                    if (slot_copy[pos] != id)
                    begin
                        kept[n_kept] = slot_copy[pos];
                        n_kept++;
                    end
                    else
                        res.entries_removed = res.entries_removed + 1'b1;
                    pos = (pos + 1) % QUEUE_DEPTH;
                end
                for (k = 0; k < n_kept; k++)
                    slot_copy[k] = kept[k];
                head_ptr = '0;
                tail_ptr = PTR_W'(n_kept % QUEUE_DEPTH);
                fill_count = COUNT_W'(n_kept);
            end
            default: ;
        endcase
        res.queue_count = fill_count;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_item_t make_req(input logic [REQ_TYPE_W-1:0] code,
                                           input logic [THREAD_ID_W-1:0] id);
        req_item_t item;
        item.req_type = code;
        item.thread_id = id;
        return item;
    endfunction

    // Random request: ids mostly from a small pool so removes find matches
    function automatic req_item_t random_req();
        logic [REQ_TYPE_W-1:0]  code;
        logic [THREAD_ID_W-1:0] id;
        int                     r;
        r = $urandom_range(0, 99);
        if (r < 45)
            code = REQ_ENQUEUE;
        else if (r < 80)
            code = REQ_DEQUEUE;
        else if (r < 95)
            code = REQ_REMOVE;
        else
            code = REQ_NOP;
        if ($urandom_range(0, 3) == 0)
            id = THREAD_ID_W'($urandom_range(0, 255));
        else
            id = id_pool[$urandom_range(0, 5)];
        return make_req(code, id);
    endfunction

    // Offer one request transaction and hold it until accepted
    task automatic send_req(input req_item_t item);
        int gap;
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        awaited_rsp.push_back(predict_request(item));
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(input string tag, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, tag, expv, actv);
            error_count++;
        end
    endtask

    // Empty queue, fill with edge ids, overflow, removes on a full queue
    task automatic test_directed();
        logic [THREAD_ID_W-1:0] fill_ids [16] = '{
            8'h00, 8'hFF, 8'h5A, 8'hFF, 8'hA5, 8'h01, 8'h80, 8'hFF,
            8'h7F, 8'hFE, 8'h10, 8'h00, 8'h33, 8'hCC, 8'hFF, 8'h42};
        int k;
        send_req(make_req(REQ_DEQUEUE, 8'hFF));
        send_req(make_req(REQ_REMOVE, 8'h00));
        send_req(make_req(REQ_NOP, 8'hFF));
        for (k = 0; k < QUEUE_DEPTH; k++)
            send_req(make_req(REQ_ENQUEUE, fill_ids[k]));
        send_req(make_req(REQ_ENQUEUE, 8'h99));
        // No match on a full queue: tail wraps to zero
        send_req(make_req(REQ_REMOVE, 8'h99));
        send_req(make_req(REQ_REMOVE, 8'hFF));
        send_req(make_req(REQ_DEQUEUE, 8'h00));
        send_req(make_req(REQ_ENQUEUE, 8'hFF));
    endtask

    task automatic test_random_mix(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_req(random_req());
    endtask

    // Hold the response side for a long stretch while requests keep coming
    task automatic test_backpressure(input int n);
        int k;
        hold_rsp_req = 1'b1;
        send_gaps = 1'b0;
        for (k = 0; k < n; k++)
            send_req(random_req());
        send_gaps = 1'b1;
    endtask

    // Back-to-back transactions with no idling on either side
    task automatic test_no_idle(input int n);
        int k;
        send_gaps = 1'b0;
        stall_on = 1'b0;
        for (k = 0; k < n; k++)
            send_req(random_req());
        send_gaps = 1'b1;
        stall_on = 1'b1;
    endtask

    initial
    begin
        slot_copy = '{default: '0};
        head_ptr = '0;
        tail_ptr = '0;
        fill_count = '0;
        error_count = 0;
        send_gaps = 1'b1;
        stall_on = 1'b1;
        hold_rsp_req = 1'b0;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix(1500);
        test_backpressure(120);
        test_no_idle(150);
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive response stall: random stretches, or one long hold on request
    initial
    begin : rsp_driver
        int n;
        rsp_stall <= 1'b0;
        forever
        begin
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                rsp_stall <= 1'b1;
                n = HOLD_CYCLES;
            end
            else if (stall_on && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                n = pick_gap() + 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                n = $urandom_range(1, 4);
            end
            repeat (n) @(posedge clk);
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, expected none actual %h", $time, rsp);
                error_count++;
            end
            else
            begin
                check_field("status", 8'(awaited_rsp[0].status), 8'(rsp.status));
                check_field("dispatched_id", awaited_rsp[0].dispatched_id, rsp.dispatched_id);
                check_field("entries_removed", 8'(awaited_rsp[0].entries_removed),
                            8'(rsp.entries_removed));
                check_field("queue_count", 8'(awaited_rsp[0].queue_count),
                            8'(rsp.queue_count));
                void'(awaited_rsp.pop_front());
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
        idle_cycles = 0;

endmodule
